@@ rtl/adc_pkg.sv @@
// Package for the audio dynamic compressor: payload structs, register
// indexes, controller states and command bundle, arithmetic constants.
// No dependencies; used by every file under rtl except adc_divider.
package adc_pkg;

    // Defaults and fixed arithmetic constants
    localparam int NUM_CHANNELS_DEF = 2;
    localparam logic [14:0] ENV_FLOOR = 15'd33;
    localparam logic [15:0] ATTACK_RST = 16'd64;
    localparam logic [14:0] THRESH_RST = 15'd16384;
    localparam logic [15:0] RATIO_RST = 16'd2048;

    // Shared divider: one quotient bit per step
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register index on the configuration port
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK = 2'd0,
        CFG_THRESH = 2'd1,
        CFG_RATIO  = 2'd2
    } adc_cfg_idx_t;

    // Input beat
    typedef struct packed {
        logic signed [15:0] sample_in;
        logic [0:0]         channel_sel;
    } adc_in_t;

    // Output beat
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [14:0]        envelope_level;
    } adc_out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV_DIV,
        ST_ENV_UPD,
        ST_GAIN,
        ST_PROD,
        ST_QUO_LOAD,
        ST_QUO_DIV,
        ST_FINISH
    } adc_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic env_upd;
        logic gain_mul;
        logic prod_mul;
        logic quo_load;
        logic out_load;
    } adc_cmd_t;

endpackage

@@ rtl/audio_dynamic_compressor.sv @@
// Top level of the feed-forward dynamic range compressor.
// Depends on adc_pkg, adc_ctrl, adc_datapath (with adc_divider).
//
//   channel  signals                               beat
//   src      src_valid/src_stall/src_data          sample_in, channel_sel
//   res      res_valid/res_stall/res_data          sample_out, envelope_level
//   cfg      cfg_valid/cfg_ready/cfg_index/cfg_data  one register write
//
// An item runs from accept to the next possible accept through two
// 16-step passes of the shared one-bit-per-cycle divider (envelope step,
// then normalizing divide) plus the load, update and multiply states.
// Reset clears the envelopes and loads the register defaults; no sweep.
// A stalled result waits in the output register; the finished item holds
// in the last state only if that register is still full.
module audio_dynamic_compressor #(
    parameter int NUM_CHANNELS = adc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  adc_pkg::adc_in_t              src_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output adc_pkg::adc_out_t             res_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [adc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    adc_pkg::adc_cmd_t cmd;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    adc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    adc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .src_data  (src_data),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_data  (res_data)
    );

endmodule

@@ rtl/adc_divider.sv @@
// Shared restoring divider, one quotient bit per step, 16-bit quotient.
// Used by adc_datapath for the envelope step and the normalizing divide.
module adc_divider (
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic [15:0] rem_init,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic [15:0] quotient
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg;
    logic [16:0] trial;
    logic        qbit;

    // One shift-subtract step; dividend bits shift out as quotient bits shift in
    always_comb
    begin
        trial = {rem_reg, quo_reg[15]};
        qbit  = (trial >= {1'b0, dvs_reg});
        if (qbit)
        begin
            rem_next = 16'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[15:0];
        end
        quo_next = {quo_reg[14:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_init;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

@@ rtl/adc_datapath.sv @@
// Datapath: config registers, per-channel envelopes, gain and product
// multipliers, shared divider, output register. Depends on adc_pkg, adc_divider.
module adc_datapath #(
    parameter int NUM_CHANNELS = adc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  adc_pkg::adc_cmd_t               cmd,
    input  adc_pkg::adc_in_t                src_data,
    input  logic                            cfg_we,
    input  logic [adc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data,
    output adc_pkg::adc_out_t               res_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers
    logic [15:0] attack_reg;
    logic [14:0] thresh_reg;
    logic [15:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg <= adc_pkg::ATTACK_RST;
            thresh_reg <= adc_pkg::THRESH_RST;
            ratio_reg  <= adc_pkg::RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adc_pkg::CFG_ATTACK: attack_reg <= cfg_data;
                adc_pkg::CFG_THRESH: thresh_reg <= cfg_data[14:0];
                adc_pkg::CFG_RATIO:  ratio_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-channel envelope store, cleared at reset
    logic [14:0] env_reg [NUM_CHANNELS];

    // Item registers
    logic signed [15:0] smp_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [14:0]        env_old_reg;
    logic               dneg_reg;
    logic [14:0]        env_new_reg;
    logic [14:0]        den_reg;
    logic               over_reg;
    logic [14:0]        excess_reg;
    logic [19:0]        gain_reg;
    logic [35:0]        mnum_reg;
    logic               ovf_reg;
    adc_pkg::adc_out_t  res_reg;

    // Accept: channel select, magnitude, signed step toward it
    logic [CH_W-1:0]    ch_in;
    logic [14:0]        mag_in;
    logic [14:0]        env_rd;
    logic signed [15:0] diff;
    logic [15:0]        diff_mag;
    logic [15:0]        attack_eff;

    always_comb
    begin
        if (NUM_CHANNELS == 1)
        begin
            ch_in = '0;
        end
        else
        begin
            ch_in = CH_W'(src_data.channel_sel);
        end
        if (src_data.sample_in == 16'sh8000)
        begin
            mag_in = 15'h7fff;
        end
        else if (src_data.sample_in[15])
        begin
            mag_in = 15'(-src_data.sample_in);
        end
        else
        begin
            mag_in = src_data.sample_in[14:0];
        end
        env_rd     = env_reg[ch_in];
        diff       = signed'({1'b0, mag_in}) - signed'({1'b0, env_rd});
        diff_mag   = diff[15] ? 16'(-diff) : 16'(diff);
        attack_eff = (attack_reg == 16'd0) ? 16'd1 : attack_reg;
    end

    // Envelope update from divider quotient
    logic [15:0] div_quo;
    logic [14:0] env_new;

    assign env_new = dneg_reg ? 15'(env_old_reg - div_quo[14:0])
                              : 15'(env_old_reg + div_quo[14:0]);

    // Gain above the knee
    logic [30:0] gain_prod;
    assign gain_prod = {16'b0, excess_reg} * {15'b0, ratio_reg};

    // Sample magnitude times gain
    logic [15:0] smag;
    logic [35:0] num_prod;
    assign smag     = smp_reg[15] ? 16'(-smp_reg) : 16'(smp_reg);
    assign num_prod = {20'b0, smag} * {16'b0, gain_reg};

    // Shared divider port mux
    logic        div_load;
    logic [15:0] div_rem_init;
    logic [15:0] div_dividend;
    logic [15:0] div_divisor;

    always_comb
    begin
        div_load = cmd.accept | cmd.quo_load;
        if (cmd.quo_load)
        begin
            div_rem_init = mnum_reg[31:16];
            div_dividend = mnum_reg[15:0];
            div_divisor  = {1'b0, den_reg};
        end
        else
        begin
            div_rem_init = 16'd0;
            div_dividend = diff_mag;
            div_divisor  = attack_eff;
        end
    end

    adc_divider u_div (
        .clk      (clk),
        .load     (div_load),
        .step     (cmd.div_step),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo)
    );

    // Saturated, signed quotient
    logic               q_big;
    logic signed [15:0] q_out;

    always_comb
    begin
        q_big = ovf_reg | div_quo[15];
        priority if (smp_reg[15])
        begin
            q_out = q_big ? 16'sh8000 : 16'(-div_quo);
        end
        else
        begin
            q_out = q_big ? 16'sh7fff : div_quo;
        end
    end

    // Envelope store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                env_reg[i] <= '0;
            end
        end
        else if (cmd.env_upd)
        begin
            env_reg[ch_reg] <= env_new;
        end
    end

    // Item pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg     <= src_data.sample_in;
            ch_reg      <= ch_in;
            env_old_reg <= env_rd;
            dneg_reg    <= diff[15];
        end
        if (cmd.env_upd)
        begin
            env_new_reg <= env_new;
            den_reg     <= (env_new > adc_pkg::ENV_FLOOR) ? env_new : adc_pkg::ENV_FLOOR;
            over_reg    <= (env_new > thresh_reg);
            excess_reg  <= 15'(env_new - thresh_reg);
        end
        if (cmd.gain_mul)
        begin
            gain_reg <= over_reg ? 20'({5'b0, thresh_reg} + {1'b0, gain_prod[30:12]})
                                 : {5'b0, env_new_reg};
        end
        if (cmd.prod_mul)
        begin
            mnum_reg <= num_prod;
        end
        if (cmd.quo_load)
        begin
            ovf_reg <= (mnum_reg[35:16] >= {5'b0, den_reg});
        end
        if (cmd.out_load)
        begin
            res_reg.sample_out     <= q_out;
            res_reg.envelope_level <= env_new_reg;
        end
    end

    assign res_data = res_reg;

endmodule

@@ rtl/adc_ctrl.sv @@
// Controller: sequences one item through the datapath and owns the
// handshake state. Depends on adc_pkg.
module adc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    output logic              res_valid,
    input  logic              res_stall,
    output adc_pkg::adc_cmd_t cmd
);

    adc_pkg::adc_state_t state_reg, state_next;
    logic [adc_pkg::DIV_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic out_valid_reg, out_valid_next;
    logic step_last;
    logic out_free;

    assign step_last = (step_cnt_reg == adc_pkg::DIV_CNT_W'(adc_pkg::DIV_STEPS - 1));
    assign out_free  = !out_valid_reg || !res_stall;

    // State, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adc_pkg::ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = '0;
        cmd           = '0;
        unique case (state_reg)
            adc_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = adc_pkg::ST_ENV_DIV;
                end
            end
            adc_pkg::ST_ENV_DIV:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last)
                begin
                    step_cnt_next = '0;
                    state_next    = adc_pkg::ST_ENV_UPD;
                end
            end
            adc_pkg::ST_ENV_UPD:
            begin
                cmd.env_upd = 1'b1;
                state_next  = adc_pkg::ST_GAIN;
            end
            adc_pkg::ST_GAIN:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = adc_pkg::ST_PROD;
            end
            adc_pkg::ST_PROD:
            begin
                cmd.prod_mul = 1'b1;
                state_next   = adc_pkg::ST_QUO_LOAD;
            end
            adc_pkg::ST_QUO_LOAD:
            begin
                cmd.quo_load = 1'b1;
                state_next   = adc_pkg::ST_QUO_DIV;
            end
            adc_pkg::ST_QUO_DIV:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last)
                begin
                    step_cnt_next = '0;
                    state_next    = adc_pkg::ST_FINISH;
                end
            end
            adc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = adc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared when the beat is taken
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign src_stall = (state_reg != adc_pkg::ST_IDLE);
    assign res_valid = out_valid_reg;

endmodule

@@ rtl/adc_checker.sv @@
// Port-level checker for audio_dynamic_compressor and its bind statement.
// Depends on adc_pkg.
module adc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              src_valid,
    input logic              src_stall,
    input logic              res_valid,
    input logic              res_stall,
    input adc_pkg::adc_out_t res_data,
    input logic              cfg_ready
);

    // An accepted item keeps the input side busy at sampled points into the second divider pass
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall ##8 src_stall ##8 src_stall ##8 src_stall)
        else $error("input taken again too early");

    // A result only appears at the end of an item in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_stall))
        else $error("result without an item in work");

    // Stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result beat changed");

    // Register port never blocks
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register port not ready");

endmodule

bind audio_dynamic_compressor adc_checker u_adc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_ready (cfg_ready)
);
